/* sv/mtd_pkg.sv */
// ---------------------------------------------------------------------------
// mtd_pkg
// Shared constants and the code-to-character lookup for the Morse decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package mtd_pkg;

    localparam int unsigned MAX_SYMBOLS = 7;
    localparam int unsigned KEY_W       = 8;   // sentinel bit above 7 symbols

    typedef logic [7:0]       t_byte;
    typedef logic [KEY_W-1:0] t_key;

    localparam t_byte CHAR_DOT   = 8'h2E;   // '.'
    localparam t_byte CHAR_DASH  = 8'h2D;   // '-'
    localparam t_byte CHAR_SLASH = 8'h2F;   // '/'
    localparam t_byte CHAR_SPACE = 8'h20;   // ' '
    localparam t_byte CHAR_STAR  = 8'h2A;   // '*'

    // Key layout: symbol i in bit i (1 = dash), a single 1 just above the
    // last symbol. Key zero stands for an empty or invalid pattern.
    function automatic t_byte mtd_decode_key(input t_key key);
        t_byte ch;
        begin
            unique case (key)
                8'b110:      ch = "A";
                8'b10001:    ch = "B";
                8'b10101:    ch = "C";
                8'b1001:     ch = "D";
                8'b10:       ch = "E";
                8'b10100:    ch = "F";
                8'b1011:     ch = "G";
                8'b10000:    ch = "H";
                8'b100:      ch = "I";
                8'b11110:    ch = "J";
                8'b1101:     ch = "K";
                8'b10010:    ch = "L";
                8'b111:      ch = "M";
                8'b101:      ch = "N";
                8'b1111:     ch = "O";
                8'b10110:    ch = "P";
                8'b11011:    ch = "Q";
                8'b1010:     ch = "R";
                8'b1000:     ch = "S";
                8'b11:       ch = "T";
                8'b1100:     ch = "U";
                8'b11000:    ch = "V";
                8'b1110:     ch = "W";
                8'b11001:    ch = "X";
                8'b11101:    ch = "Y";
                8'b10011:    ch = "Z";
                8'b111111:   ch = "0";
                8'b111110:   ch = "1";
                8'b111100:   ch = "2";
                8'b111000:   ch = "3";
                8'b110000:   ch = "4";
                8'b100000:   ch = "5";
                8'b100001:   ch = "6";
                8'b100011:   ch = "7";
                8'b100111:   ch = "8";
                8'b101111:   ch = "9";
                8'b1101010:  ch = ".";
                8'b1110011:  ch = ",";
                8'b1001100:  ch = "?";
                8'b1011110:  ch = 8'h27;   // apostrophe
                8'b1110101:  ch = "!";
                8'b101001:   ch = "/";
                8'b101101:   ch = "(";
                8'b1101101:  ch = ")";
                8'b100010:   ch = "&";
                8'b1000111:  ch = ":";
                8'b1010101:  ch = ";";
                8'b110001:   ch = "=";
                8'b101010:   ch = "+";
                8'b1100001:  ch = "-";
                8'b1101100:  ch = "_";
                8'b1010010:  ch = 8'h22;   // double quote
                8'b11001000: ch = "$";
                8'b1010110:  ch = "@";
                default:     ch = CHAR_STAR;
            endcase
            return ch;
        end
    endfunction

endpackage

`default_nettype wire

/* sv/morse_text_decoder_top.sv */
// ---------------------------------------------------------------------------
// morse_text_decoder_top
// Builds dot/dash patterns from a text stream and emits decoded characters.
// ---------------------------------------------------------------------------
//  channel | dir | tdata                 | tlast
//  s       | in  | [7:0] in_byte         | end_of_message
//  m       | out | [7:0] out_char        | last
//
//  One input byte per cycle while o_s_tready is high. A decode passes a
//  key register, then a registered table read that loads the output
//  register, before its character appears. A space byte gives two
//  output transactions, which holds the input until the second is taken
//  only when the next decode is already waiting in the key stage.
//  Synchronous active-low reset clears the pattern and empties the pipe.
//  Output stalls back up through the key stage into o_s_tready.
// ---------------------------------------------------------------------------
`default_nettype none

module morse_text_decoder_top (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_s_tvalid,
    output logic                o_s_tready,
    input  wire mtd_pkg::t_byte i_s_tdata,   // [7:0] in_byte
    input  wire                 i_s_tlast,   // end_of_message
    output logic                o_m_tvalid,
    input  wire                 i_m_tready,
    output mtd_pkg::t_byte      o_m_tdata,   // [7:0] out_char
    output logic                o_m_tlast    // last
);
    import mtd_pkg::*;

    // pattern state
    logic [MAX_SYMBOLS-1:0] r_bits, n_bits;
    logic [2:0]             r_cnt,  n_cnt;
    logic                   r_inv,  n_inv;

    // key stage
    logic r_k_vld;
    t_key r_k_key;
    logic r_k_sp;

    // output stage
    logic  r_o_vld;
    t_byte r_o_char;
    logic  r_o_sp;
    logic  r_o_phase;   // 1 while the trailing space is shown

    logic                   s_acc, is_dot, is_dash, is_space, is_slash, do_dec;
    logic [MAX_SYMBOLS-1:0] a_bits, d_bits;
    logic [2:0]             a_cnt,  d_cnt;
    logic                   a_inv,  d_inv;
    t_key                   dec_key;
    logic                   o_done, o_load, k_adv;

    assign is_dot   = (i_s_tdata == CHAR_DOT);
    assign is_dash  = (i_s_tdata == CHAR_DASH);
    assign is_space = (i_s_tdata == CHAR_SPACE);
    assign is_slash = (i_s_tdata == CHAR_SLASH);
    assign do_dec   = is_space || is_slash || i_s_tlast;

    // append the byte to the pattern; overflow or a non-symbol byte marks it invalid
    always_comb begin
        a_bits = r_bits;
        a_cnt  = r_cnt;
        a_inv  = r_inv;
        if (is_dot || is_dash) begin
            if (r_cnt == 3'(MAX_SYMBOLS)) begin
                a_inv = 1'b1;
            end else begin
                if (is_dash) begin
                    a_bits = r_bits | (MAX_SYMBOLS'(1) << r_cnt);
                end
                a_cnt = r_cnt + 3'd1;
            end
        end else begin
            a_inv = 1'b1;
        end
    end

    // separators decode the stored pattern, other bytes the appended one
    always_comb begin
        if (is_space || is_slash) begin
            d_bits = r_bits;
            d_cnt  = r_cnt;
            d_inv  = r_inv;
        end else begin
            d_bits = a_bits;
            d_cnt  = a_cnt;
            d_inv  = a_inv;
        end
        if (d_inv || d_cnt == 3'd0) begin
            dec_key = '0;
        end else begin
            dec_key = (KEY_W'(1) << d_cnt) | KEY_W'(d_bits);
        end
    end

    assign o_done     = r_o_vld && i_m_tready && o_m_tlast;
    assign o_load     = !r_o_vld || o_done;
    assign k_adv      = r_k_vld && o_load;
    assign o_s_tready = !r_k_vld || k_adv;
    assign s_acc      = i_s_tvalid && o_s_tready;

    always_comb begin
        n_bits = r_bits;
        n_cnt  = r_cnt;
        n_inv  = r_inv;
        if (s_acc) begin
            if (do_dec) begin
                n_bits = '0;
                n_cnt  = '0;
                n_inv  = 1'b0;
            end else begin
                n_bits = a_bits;
                n_cnt  = a_cnt;
                n_inv  = a_inv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
            r_cnt  <= '0;
            r_inv  <= 1'b0;
        end else begin
            r_bits <= n_bits;
            r_cnt  <= n_cnt;
            r_inv  <= n_inv;
        end
    end

    // key stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_k_vld <= s_acc && do_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready) begin
            r_k_key <= dec_key;
            r_k_sp  <= is_space;
        end
    end

    // output stage: registered table read, then one or two transactions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld   <= 1'b0;
            r_o_phase <= 1'b0;
        end else begin
            if (o_load) begin
                r_o_vld   <= r_k_vld;
                r_o_phase <= 1'b0;
            end else if (r_o_vld && i_m_tready) begin
                r_o_phase <= 1'b1;   // advance to the trailing space
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_o_char <= mtd_decode_key(r_k_key);
            r_o_sp   <= r_k_sp;
        end
    end

    assign o_m_tvalid = r_o_vld;
    assign o_m_tdata  = r_o_phase ? CHAR_SPACE : r_o_char;
    assign o_m_tlast  = r_o_phase || !r_o_sp;

endmodule

`default_nettype wire
